@@ rtl/core/mbps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants and types for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

   localparam int MAX_PATTERN   = 24;
   localparam int OFFSET_BITS   = 32;
   localparam int PATTERN_SLOTS = 24;
   localparam int OFFSET_OUT_W  = 32;
   localparam int WIN_IDX_BITS  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 64;
   localparam int LEN_BITS      = 5;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_MID  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_HIGH = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CARE_MASK    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_LEN  = 3'd4;

   localparam logic [OFFSET_BITS-1:0] COUNT_TOP = '1;

   typedef logic [MAX_PATTERN-1:0][7:0]   window_type;
   typedef logic [PATTERN_SLOTS-1:0][7:0] pattern_type;

   typedef struct packed {
      pattern_type               pattern;
      logic [PATTERN_SLOTS-1:0]  care;
      logic [LEN_BITS-1:0]       length;
   } cfg_type;

   typedef struct packed {
      window_type                window;
      logic [OFFSET_BITS-1:0]    count;
   } stage_type;

endpackage
`default_nettype wire

@@ rtl/core/mbps_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_req_if
// Input byte channel: one data byte per beat with a region-end marker.
// ----------------------------------------------------------------------------
interface mbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source(output valid, output data_byte, output last_byte, input ready);
   modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/core/mbps_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_rsp_if
// Result channel: region offset of a matching window per beat.
// ----------------------------------------------------------------------------
interface mbps_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [mbps_pkg::OFFSET_OUT_W-1:0]  match_offset;

   modport source(output valid, output match_offset, input ready);
   modport sink(input valid, input match_offset, output ready);
endinterface
`default_nettype wire

@@ rtl/core/mbps_csr_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_csr_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface mbps_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mbps_pkg::CSR_IDX_BITS-1:0]   index;
   logic [mbps_pkg::CSR_DATA_BITS-1:0]  data;

   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/mbps_csr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_csr
// Configuration registers: pattern bytes, care mask and pattern length.
// ----------------------------------------------------------------------------
module mbps_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   mbps_csr_if.sink         csr_if,
   output mbps_pkg::cfg_type cfg
);

   logic [63:0]                        pat_low_ff;
   logic [63:0]                        pat_mid_ff;
   logic [63:0]                        pat_high_ff;
   logic [mbps_pkg::PATTERN_SLOTS-1:0] care_ff;
   logic [mbps_pkg::LEN_BITS-1:0]      length_ff;
   logic                               write;

   assign csr_if.ready = 1'b1;
   assign write        = csr_if.valid && csr_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_mid_ff  <= '0;
         pat_high_ff <= '0;
         care_ff     <= '0;
         length_ff   <= '0;
      end else if (write) begin
         case (csr_if.index)
            mbps_pkg::CSR_PATTERN_LOW:  pat_low_ff  <= csr_if.data;
            mbps_pkg::CSR_PATTERN_MID:  pat_mid_ff  <= csr_if.data;
            mbps_pkg::CSR_PATTERN_HIGH: pat_high_ff <= csr_if.data;
            mbps_pkg::CSR_CARE_MASK:
               care_ff <= csr_if.data[mbps_pkg::PATTERN_SLOTS-1:0];
            mbps_pkg::CSR_PATTERN_LEN:
               length_ff <= csr_if.data[mbps_pkg::LEN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.pattern = {pat_high_ff, pat_mid_ff, pat_low_ff};
   assign cfg.care    = care_ff;
   assign cfg.length  = length_ff;

endmodule
`default_nettype wire

@@ rtl/core/mbps_window.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_window
// Sliding byte window and region byte count; registers a snapshot per beat.
// ----------------------------------------------------------------------------
module mbps_window (
   input  wire logic          clock,
   input  wire logic          reset,
   mbps_req_if.sink           req_if,
   output logic               stage_valid,
   input  wire logic          stage_ready,
   output mbps_pkg::stage_type stage
);

   mbps_pkg::window_type               window_ff;
   mbps_pkg::window_type               window_in;
   logic [mbps_pkg::OFFSET_BITS-1:0]   count_ff;
   logic [mbps_pkg::OFFSET_BITS-1:0]   count_in;
   logic                               stage_valid_ff;
   mbps_pkg::stage_type                stage_ff;
   logic                               accept;

   assign req_if.ready = !stage_valid_ff || stage_ready;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      window_in = {window_ff[mbps_pkg::MAX_PATTERN-2:0], req_if.data_byte};
      count_in  = (count_ff == mbps_pkg::COUNT_TOP) ? count_ff
                                                    : count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= '0;
         count_ff       <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            window_ff      <= req_if.last_byte ? '0 : window_in;
            count_ff       <= req_if.last_byte ? '0 : count_in;
            stage_valid_ff <= 1'b1;
         end else if (stage_ready) begin
            stage_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff.window <= window_in;
         stage_ff.count  <= count_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

endmodule
`default_nettype wire

@@ rtl/core/mbps_match.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_match
// Parallel masked compare of the window snapshot and result register.
// ----------------------------------------------------------------------------
module mbps_match (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           stage_valid,
   output logic                stage_ready,
   input  mbps_pkg::stage_type stage,
   input  mbps_pkg::cfg_type   cfg,
   mbps_rsp_if.source          rsp_if
);

   logic                                    len_ok;
   logic                                    hit;
   logic [mbps_pkg::WIN_IDX_BITS-1:0]       idx;
   logic [mbps_pkg::OFFSET_BITS-1:0]        diff;
   logic [mbps_pkg::OFFSET_BITS+mbps_pkg::OFFSET_OUT_W-1:0] diff_ext;
   logic                                    rsp_valid_ff;
   logic [mbps_pkg::OFFSET_OUT_W-1:0]       offset_ff;
   logic                                    out_free;
   logic                                    take;

   always_comb begin
      len_ok = (cfg.length != '0) &&
               (int'(cfg.length) <= mbps_pkg::PATTERN_SLOTS) &&
               (int'(cfg.length) <= mbps_pkg::MAX_PATTERN) &&
               (stage.count >= mbps_pkg::OFFSET_BITS'(cfg.length));
      hit = len_ok;
      idx = '0;
      for (int j = 0; j < mbps_pkg::PATTERN_SLOTS; j++) begin
         idx = mbps_pkg::WIN_IDX_BITS'(cfg.length - 1'b1 - mbps_pkg::LEN_BITS'(j));
         if ((j < int'(cfg.length)) && cfg.care[j] && len_ok) begin
            if (stage.window[idx] != cfg.pattern[j]) begin
               hit = 1'b0;
            end
         end
      end
      diff     = stage.count - mbps_pkg::OFFSET_BITS'(cfg.length);
      diff_ext = {{mbps_pkg::OFFSET_OUT_W{1'b0}}, diff};
   end

   assign out_free    = !rsp_valid_ff || rsp_if.ready;
   assign stage_ready = out_free;
   assign take        = stage_valid && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= hit;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && hit) begin
         offset_ff <= diff_ext[mbps_pkg::OFFSET_OUT_W-1:0];
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.match_offset = offset_ff;

endmodule
`default_nettype wire

@@ rtl/core/masked_byte_pattern_scanner_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_top
// Wildcard byte signature search over a byte stream, one byte per beat.
// Path: accepted byte -> window snapshot register -> result register.
// Throughput: one byte per cycle (window, result registers) unless rsp_if stalls.
// Reset: synchronous; clears window, count, configuration and pending beats.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_top (
   input  wire logic   clock,
   input  wire logic   reset,
   mbps_req_if.sink    req_if,
   mbps_rsp_if.source  rsp_if,
   mbps_csr_if.sink    csr_if
);

   mbps_pkg::cfg_type   cfg;
   mbps_pkg::stage_type stage;
   logic                stage_valid;
   logic                stage_ready;

   mbps_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   mbps_window u_window (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .stage_valid (stage_valid),
      .stage_ready (stage_ready),
      .stage       (stage)
   );

   mbps_match u_match (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_ready (stage_ready),
      .stage       (stage),
      .cfg         (cfg),
      .rsp_if      (rsp_if)
   );

endmodule
`default_nettype wire
